[hw/rtl/fraction_reducer_top_macros.svh]
// assertion macros for the fraction reducer
`ifndef FRACTION_REDUCER_TOP_MACROS_SVH
`define FRACTION_REDUCER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define FR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication, disabled while reset is active
`define FR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

[hw/rtl/fr_pkg.sv]
// shared types for the fraction reducer
package fr_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD_CHK,
    ST_GCD_WAIT,
    ST_NDIV_WAIT,
    ST_DDIV_WAIT
  } fr_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } fr_div_stat_t;

endpackage

[hw/rtl/fr_div.sv]
// shared restoring divider, one quotient bit per cycle
module fr_div #(
  parameter int WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [WIDTH-1:0]   dividend_i,
  input  logic [WIDTH-1:0]   divisor_i,
  output logic [WIDTH-1:0]   quo_o,
  output logic [WIDTH-1:0]   rem_o,
  output fr_pkg::fr_div_stat_t stat_o
);

  localparam int CW = $clog2(WIDTH);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH+1:0] diff;

  assign rem_sh = {rem_q, quo_q[WIDTH-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      if (diff[WIDTH+1]) begin
        rem_d = rem_sh[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b0};
      end else begin
        rem_d = diff[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b1};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quo_o       = quo_q;
  assign rem_o       = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

[hw/rtl/fraction_reducer_top.sv]
// fraction reducer top level: sequencer around a shared divider
//
// Reduces one signed fraction num_i/den_i to lowest terms.
// A request is taken at a rising edge with start high and busy low; busy then
// stays high until the result is out unless den_i is zero. The result appears
// on num_o, den_o and bad_denominator_o, marked by valid_o, which is high for
// exactly one cycle; the receiver cannot stall and must take it in that cycle.
// Work runs on one restoring divider that yields one quotient bit per cycle
// while busy, and it reports done in the cycle after its last quotient bit.
// The gcd uses k Euclid remainder steps (k is at most about 1.44*WIDTH, often
// far fewer), each a check state and a division of x by y; after a final
// check the numerator and the denominator are divided by the gcd back to
// back. A zero denominator is reported in the cycle right after the request
// edge, with zero outputs and bad_denominator_o high.
// The next request can be given in the cycle valid_o is high.
// Reset clears the sequencer and the divider; no request is pending after it.
module fraction_reducer_top #(
  parameter int WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [WIDTH-1:0] num_i,
  input  logic signed [WIDTH-1:0] den_i,
  output logic                    valid_o,
  output logic signed [WIDTH-1:0] num_o,
  output logic        [WIDTH-2:0] den_o,
  output logic                    bad_denominator_o
);

  fr_pkg::fr_state_e state_q, state_d;

  logic [WIDTH-1:0] nm_q, nm_d, dm_q, dm_d;
  logic [WIDTH-1:0] x_q, x_d, y_q, y_d, rn_q, rn_d;
  logic             nneg_q, nneg_d, dneg_q, dneg_d;
  logic             valid_q, valid_d;
  logic [WIDTH-1:0] num_q, num_d;
  logic [WIDTH-2:0] den_q, den_d;
  logic             bad_q, bad_d;

  logic             div_start;
  logic [WIDTH-1:0] div_a, div_b, div_quo, div_rem;
  fr_pkg::fr_div_stat_t div_stat;

  logic             in_nneg, in_dneg;
  logic [WIDTH-1:0] in_nm, in_dm;
  logic             accept;
  logic [WIDTH-2:0] rd_sat;

  assign accept  = start && !busy;
  assign in_nneg = num_i[WIDTH-1];
  assign in_dneg = den_i[WIDTH-1];
  assign in_nm   = in_nneg ? (~num_i + WIDTH'(1)) : num_i;
  assign in_dm   = in_dneg ? (~den_i + WIDTH'(1)) : den_i;

  fr_div #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .stat_o     (div_stat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fr_pkg::ST_IDLE: begin
        if (accept && (in_dm != '0)) state_d = fr_pkg::ST_GCD_CHK;
      end
      fr_pkg::ST_GCD_CHK: begin
        if (y_q == '0) state_d = fr_pkg::ST_NDIV_WAIT;
        else           state_d = fr_pkg::ST_GCD_WAIT;
      end
      fr_pkg::ST_GCD_WAIT: begin
        if (div_stat.done) state_d = fr_pkg::ST_GCD_CHK;
      end
      fr_pkg::ST_NDIV_WAIT: begin
        if (div_stat.done) state_d = fr_pkg::ST_DDIV_WAIT;
      end
      fr_pkg::ST_DDIV_WAIT: begin
        if (div_stat.done) state_d = fr_pkg::ST_IDLE;
      end
      default: state_d = fr_pkg::ST_IDLE;
    endcase
  end

  // saturated reduced denominator from the last division
  assign rd_sat = div_quo[WIDTH-1] ? {(WIDTH-1){1'b1}} : div_quo[WIDTH-2:0];

  // datapath and outputs
  always_comb begin
    nm_d      = nm_q;
    dm_d      = dm_q;
    x_d       = x_q;
    y_d       = y_q;
    rn_d      = rn_q;
    nneg_d    = nneg_q;
    dneg_d    = dneg_q;
    valid_d   = 1'b0;
    num_d     = num_q;
    den_d     = den_q;
    bad_d     = bad_q;
    div_start = 1'b0;
    div_a     = x_q;
    div_b     = y_q;
    unique case (state_q)
      fr_pkg::ST_IDLE: begin
        if (accept) begin
          nm_d   = in_nm;
          dm_d   = in_dm;
          x_d    = in_nm;
          y_d    = in_dm;
          nneg_d = in_nneg;
          dneg_d = in_dneg;
          if (in_dm == '0) begin
            valid_d = 1'b1;
            num_d   = '0;
            den_d   = '0;
            bad_d   = 1'b1;
          end
        end
      end
      fr_pkg::ST_GCD_CHK: begin
        div_start = 1'b1;
        if (y_q == '0) begin
          div_a = nm_q;
          div_b = x_q;
        end
      end
      fr_pkg::ST_GCD_WAIT: begin
        if (div_stat.done) begin
          x_d = y_q;
          y_d = div_rem;
        end
      end
      fr_pkg::ST_NDIV_WAIT: begin
        div_a = dm_q;
        div_b = x_q;
        if (div_stat.done) begin
          rn_d      = div_quo;
          div_start = 1'b1;
        end
      end
      fr_pkg::ST_DDIV_WAIT: begin
        if (div_stat.done) begin
          valid_d = 1'b1;
          bad_d   = 1'b0;
          if (rn_q == '0) begin
            num_d = '0;
            den_d = (WIDTH-1)'(1);
          end else begin
            den_d = rd_sat;
            if (nneg_q != dneg_q) num_d = ~rn_q + WIDTH'(1);
            else if (rn_q[WIDTH-1]) num_d = {1'b0, {(WIDTH-1){1'b1}}};
            else num_d = rn_q;
          end
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fr_pkg::ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nm_q   <= nm_d;
    dm_q   <= dm_d;
    x_q    <= x_d;
    y_q    <= y_d;
    rn_q   <= rn_d;
    nneg_q <= nneg_d;
    dneg_q <= dneg_d;
    num_q  <= num_d;
    den_q  <= den_d;
    bad_q  <= bad_d;
  end

  assign busy              = (state_q != fr_pkg::ST_IDLE);
  assign valid_o           = valid_q;
  assign num_o             = num_q;
  assign den_o             = den_q;
  assign bad_denominator_o = bad_q;

`include "fraction_reducer_top_macros.svh"

  `FR_ASSERT_IMP(a_bad_zero, clk_i, rst_ni, valid_o && bad_denominator_o, (num_o == '0) && (den_o == '0))
  `FR_ASSERT_IMP(a_den_nonzero, clk_i, rst_ni, valid_o && !bad_denominator_o, den_o != '0)
  `FR_ASSERT_IMP(a_zero_num, clk_i, rst_ni, valid_o && !bad_denominator_o && (num_o == '0), den_o == (WIDTH-1)'(1))
  `FR_ASSERT_NXT(a_req_busy, clk_i, rst_ni, start && !busy && (den_i != '0), busy && !valid_o)

endmodule
